// File: rtl/assert_macros.svh
// Assertion helper macros shared by the mapper RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CBM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define CBM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; imported by cbm_core and cartridge_bank_mapper.
package cbm_pkg;

   localparam int OFF_W   = 23;
   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 8;
   localparam int CSR_IDX_W = 2;

   // Operation codes of an input beat.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CART_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_LOG2  = 2'd1;

   localparam logic [7:0] CART_TYPE_RESET = 8'h00;
   localparam logic [4:0] ROM_LOG2_MIN    = 5'd15;

   typedef enum logic [2:0] {
      TGT_ROM      = 3'd0,
      TGT_EXT_RAM  = 3'd1,
      TGT_NIBBLE   = 3'd2,
      TGT_RTC      = 3'd3,
      TGT_DISABLED = 3'd4,
      TGT_NOT_CART = 3'd5,
      TGT_CONTROL  = 3'd6
   } target_type;

   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_MBC1 = 3'd1,
      KIND_MBC2 = 3'd2,
      KIND_MBC3 = 3'd3,
      KIND_MBC5 = 3'd5
   } kind_type;

   typedef struct packed {
      logic [8:0] rom_bank;
      logic [3:0] ram_bank;
      logic       ram_enable;
      logic       banking_mode;
      logic       rtc_select;
   } map_state_type;

   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } item_type;

   typedef struct packed {
      target_type        target;
      logic [OFF_W-1:0]  offset;
      logic [2:0]        rtc_index;
      logic [DATA_W-1:0] store_data;
   } result_type;

endpackage

// File: rtl/cbm_core.sv
// Combinational mapper datapath: register updates and address translation.
// Depends on cbm_pkg.
module cbm_core import cbm_pkg::*; #(
   parameter int EXT_RAM_ADDR_BITS = 15,
   parameter int MAX_ROM_LOG2      = 23
) (
   input  item_type      item,
   input  map_state_type state_cur,
   input  logic [7:0]    cart_type,
   input  logic [4:0]    rom_log2,
   output map_state_type state_nxt,
   output result_type    result
);

   localparam logic [OFF_W-1:0] RAM_MASK = OFF_W'((24'd1 << EXT_RAM_ADDR_BITS) - 24'd1);
   localparam logic [4:0]       ROM_LOG2_MAX = 5'(MAX_ROM_LOG2);

   kind_type         kind;
   logic [4:0]       rom_lg;
   logic [OFF_W-1:0] rom_mask;
   logic             enable_code;
   logic [4:0]       bank5;
   logic [3:0]       bank4;
   logic [6:0]       bank7;
   logic [DATA_W-1:0] wdata;
   logic [ADDR_W-1:0] a;

   always_comb begin
      unique case (cart_type) inside
         [8'h01:8'h03]: kind = KIND_MBC1;
         8'h05, 8'h06:  kind = KIND_MBC2;
         [8'h0F:8'h13]: kind = KIND_MBC3;
         [8'h19:8'h1E]: kind = KIND_MBC5;
         default:       kind = KIND_NONE;
      endcase
   end

   // ROM size clamped into the supported range, then expanded to a bit mask.
   always_comb begin
      if (rom_log2 < ROM_LOG2_MIN) begin
         rom_lg = ROM_LOG2_MIN;
      end else if (rom_log2 > ROM_LOG2_MAX) begin
         rom_lg = ROM_LOG2_MAX;
      end else begin
         rom_lg = rom_log2;
      end
      for (int i = 0; i < OFF_W; i++) begin
         rom_mask[i] = (5'(i) < rom_lg);
      end
   end

   assign a           = item.addr;
   assign wdata       = item.data;
   assign enable_code = (wdata[3:0] == 4'hA);
   // A bank number of zero selects bank one on these mappers.
   assign bank5 = (wdata[4:0] == 5'd0) ? 5'd1 : wdata[4:0];
   assign bank4 = (wdata[3:0] == 4'd0) ? 4'd1 : wdata[3:0];
   assign bank7 = (wdata[6:0] == 7'd0) ? 7'd1 : wdata[6:0];

   always_comb begin
      state_nxt         = state_cur;
      result.target     = TGT_NOT_CART;
      result.offset     = '0;
      result.rtc_index  = '0;
      result.store_data = (item.opcode == OP_WRITE) ? wdata : '0;

      if (!a[15] && item.opcode == OP_WRITE) begin
         result.target = TGT_CONTROL;
         case (kind)
            KIND_MBC1: begin
               unique case (a[14:13])
                  2'd0: state_nxt.ram_enable = enable_code;
                  2'd1: state_nxt.rom_bank = {2'b00, state_cur.rom_bank[6:5], bank5};
                  2'd2: begin
                     if (!state_cur.banking_mode) begin
                        state_nxt.rom_bank = {2'b00, wdata[1:0], state_cur.rom_bank[4:0]};
                     end else begin
                        state_nxt.ram_bank = {2'b00, wdata[1:0]};
                     end
                  end
                  2'd3: state_nxt.banking_mode = wdata[0];
               endcase
            end
            KIND_MBC2: begin
               if (!a[14]) begin
                  if (!a[8]) begin
                     state_nxt.ram_enable = enable_code;
                  end else begin
                     state_nxt.rom_bank = {5'd0, bank4};
                  end
               end
            end
            KIND_MBC3: begin
               unique case (a[14:13])
                  2'd0: state_nxt.ram_enable = enable_code;
                  2'd1: state_nxt.rom_bank = {2'b00, bank7};
                  2'd2: begin
                     if (wdata <= 8'h03) begin
                        state_nxt.ram_bank   = wdata[3:0];
                        state_nxt.rtc_select = 1'b0;
                     end else if (wdata >= 8'h08 && wdata <= 8'h0C) begin
                        state_nxt.ram_bank   = wdata[3:0];
                        state_nxt.rtc_select = 1'b1;
                     end
                  end
                  2'd3: ;  // RTC latch writes have no effect here.
               endcase
            end
            KIND_MBC5: begin
               unique case (a[14:13])
                  2'd0: state_nxt.ram_enable = enable_code;
                  2'd1: begin
                     if (!a[12]) begin
                        state_nxt.rom_bank = {state_cur.rom_bank[8], wdata};
                     end else begin
                        state_nxt.rom_bank = {wdata[0], state_cur.rom_bank[7:0]};
                     end
                  end
                  2'd2: state_nxt.ram_bank = wdata[3:0];
                  2'd3: ;
               endcase
            end
            default: ;
         endcase
      end else if (!a[15]) begin
         result.target = TGT_ROM;
         if (!a[14]) begin
            result.offset = {7'd0, a};
            if (kind == KIND_MBC1 && state_cur.banking_mode) begin
               result.offset[20:19] = state_cur.rom_bank[6:5];
            end
         end else begin
            result.offset = {state_cur.rom_bank, a[13:0]};
         end
         result.offset = result.offset & rom_mask;
      end else if (a[15:13] == 3'b101) begin
         if (!state_cur.ram_enable) begin
            result.target = TGT_DISABLED;
         end else if (kind == KIND_MBC2) begin
            result.target     = TGT_NIBBLE;
            result.offset     = {14'd0, a[8:0]};
            result.store_data = {4'd0, result.store_data[3:0]};
         end else if (kind == KIND_MBC3 && state_cur.rtc_select) begin
            if (state_cur.ram_bank >= 4'd8 && state_cur.ram_bank <= 4'd12) begin
               result.target    = TGT_RTC;
               result.rtc_index = state_cur.ram_bank[2:0];
            end else begin
               result.target = TGT_DISABLED;
            end
         end else begin
            result.target = TGT_EXT_RAM;
            result.offset = {6'd0, state_cur.ram_bank, a[12:0]} & RAM_MASK;
         end
      end
   end

endmodule

// File: rtl/cartridge_bank_mapper.sv
// Cartridge bank mapper: a request beat is held in the input register, then in the
// result register that drives its response beat. One request beat is taken every
// cycle when responses drain, set by a single pass through the translate logic
// between the input and result registers. Synchronous active-high reset clears the
// valid flags, sets the bank registers (ROM bank one, all else zero) and selects no
// mapper, 32 KiB ROM. Depends on cbm_pkg, cbm_core and assert_macros.svh.
`include "assert_macros.svh"

module cartridge_bank_mapper import cbm_pkg::*; #(
   parameter int EXT_RAM_ADDR_BITS = 15,
   parameter int MAX_ROM_LOG2      = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   // Configuration write channel.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_write_data,
   // Request channel.
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  logic [15:0]          req_bus_address,
   input  logic [7:0]           req_write_data,
   // Response channel.
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_target,
   output logic [22:0]          rsp_physical_offset,
   output logic [2:0]           rsp_rtc_index,
   output logic [7:0]           rsp_store_data,
   output logic [8:0]           rsp_current_rom_bank,
   output logic [3:0]           rsp_current_ram_bank
);

   // Configuration registers. The port never stalls; the user must issue writes only
   // while the mapper holds no beat in flight, which the block does not enforce.
   logic [7:0]    cart_type_ff;
   logic [4:0]    rom_log2_ff;

   // Mapper state, updated when a write beat passes through the translate stage.
   map_state_type state_ff;
   map_state_type state_in;

   // Input register stage.
   logic          s1_valid_ff;
   item_type      s1_item_ff;
   logic          s1_advance;

   // Result register stage.
   logic          out_valid_ff;
   result_type    out_result_ff;
   map_state_type out_state_ff;
   result_type    result_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff <= CART_TYPE_RESET;
         rom_log2_ff  <= ROM_LOG2_MIN;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CART_TYPE: cart_type_ff <= csr_write_data;
            CSR_ROM_LOG2:  rom_log2_ff  <= csr_write_data[4:0];
            default:       ;  // Writes past the register list are dropped.
         endcase
      end
   end

   // The result register frees up when empty or when its beat is taken, and the
   // input stage moves forward at the same moment, so a new beat enters every
   // cycle while the consumer keeps up.
   assign s1_advance = !out_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff.opcode <= req_opcode;
         s1_item_ff.addr   <= req_bus_address;
         s1_item_ff.data   <= req_write_data;
      end
   end

   cbm_core #(
      .EXT_RAM_ADDR_BITS (EXT_RAM_ADDR_BITS),
      .MAX_ROM_LOG2      (MAX_ROM_LOG2)
   ) u_core (
      .item      (s1_item_ff),
      .state_cur (state_ff),
      .cart_type (cart_type_ff),
      .rom_log2  (rom_log2_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // Bank registers commit as the beat that changed them moves to the result
   // register, so the next beat in the input stage always sees them current.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.rom_bank     <= 9'd1;
         state_ff.ram_bank     <= 4'd0;
         state_ff.ram_enable   <= 1'b0;
         state_ff.banking_mode <= 1'b0;
         state_ff.rtc_select   <= 1'b0;
      end else if (s1_valid_ff && s1_advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         out_result_ff <= result_in;
         out_state_ff  <= state_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_target           = out_result_ff.target;
   assign rsp_physical_offset  = out_result_ff.offset;
   assign rsp_rtc_index        = out_result_ff.rtc_index;
   assign rsp_store_data       = out_result_ff.store_data;
   assign rsp_current_rom_bank = out_state_ff.rom_bank;
   assign rsp_current_ram_bank = out_state_ff.ram_bank;

   // Reset leaves ROM bank one selected and RAM disabled.
   `CBM_ASSERT_ALWAYS(a_reset_state, reset |=> (state_ff.rom_bank == 9'd1 && !state_ff.ram_enable), "mapper state not reset")
   // Bank registers move only when a write beat leaves the input stage.
   `CBM_ASSERT(a_state_hold, !(s1_valid_ff && s1_advance && s1_item_ff.opcode == OP_WRITE) |=> $stable(state_ff), "mapper state changed without a write beat")
   // An empty result register never blocks the request side.
   `CBM_ASSERT(a_ready_free, !out_valid_ff |-> req_ready, "request stalled with empty result register")
   // Nibble RAM stores carry only the low four data bits.
   `CBM_ASSERT(a_nibble_data, (out_valid_ff && rsp_target == TGT_NIBBLE) |-> (rsp_store_data[7:4] == 4'd0), "nibble store with high bits set")
   // The RTC index is reported only with the RTC target.
   `CBM_ASSERT(a_rtc_index, (out_valid_ff && rsp_target != TGT_RTC) |-> (rsp_rtc_index == 3'd0), "RTC index set for non-RTC target")

endmodule

// File: test/cartridge_bank_mapper_tb.sv
// Self-checking testbench for cartridge_bank_mapper: directed and random bus accesses
// against a cycle-free predictor of the mapper registers and address translation.
// Depends on cbm_pkg and the cartridge_bank_mapper RTL; reads no files.
module cartridge_bank_mapper_tb import cbm_pkg::*; ();

   // The block is built with its default sizes; the predictor uses the same values.
   localparam int EXT_RAM_BITS     = 15;
   localparam int ROM_LOG2_MAX     = 23;
   localparam int ITEMS_PER_PHASE  = 100;
   localparam int RANDOM_PHASES    = 11;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 300;

   // Cartridge types for the random phases. Every mapper kind shows up, both ends of
   // the byte range decode to no mapper, and the last entry is replaced by a random byte.
   localparam logic [7:0] PHASE_TYPES [RANDOM_PHASES] = '{
      8'h01, 8'h05, 8'h13, 8'h1E, 8'h00, 8'hFF, 8'h02, 8'h0F, 8'h19, 8'h06, 8'h11
   };

   // What one accepted access must produce on the response channel.
   typedef struct packed {
      target_type  target;
      logic [22:0] offset;
      logic [2:0]  rtc_index;
      logic [7:0]  store_data;
      logic [8:0]  rom_bank;
      logic [3:0]  ram_bank;
   } translation_type;

   // Every input of the block holds a known value from time zero.
   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_CART_TYPE;
   logic [7:0]           csr_write_data = 8'h00;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_opcode     = OP_READ;
   logic [15:0]          req_bus_address = 16'h0000;
   logic [7:0]           req_write_data = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [2:0]           rsp_target;
   logic [22:0]          rsp_physical_offset;
   logic [2:0]           rsp_rtc_index;
   logic [7:0]           rsp_store_data;
   logic [8:0]           rsp_current_rom_bank;
   logic [3:0]           rsp_current_ram_bank;

   // Predicted configuration and mapper registers, starting from their reset values.
   logic [7:0]    cart_type_cfg = CART_TYPE_RESET;
   logic [4:0]    rom_log2_cfg  = ROM_LOG2_MIN;
   map_state_type mapper_regs   = '{9'd1, 4'd0, 1'b0, 1'b0, 1'b0};

   // Accesses waiting to be driven, and translations waiting for their response beat.
   item_type        access_queue[$];
   translation_type expected_translations[$];

   // Handshake bookkeeping shared between the clocked processes.
   logic req_beat = 1'b0;
   int   req_gap_left, req_calm_left;
   int   rsp_hold_left, rsp_calm_left, long_hold_left;
   bit   long_hold_done;
   int   idle_cycles;

   int mismatch_count, results_checked, settings_used;
   int target_hits [7];

   cartridge_bank_mapper #(
      .EXT_RAM_ADDR_BITS(EXT_RAM_BITS),
      .MAX_ROM_LOG2     (ROM_LOG2_MAX)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_bus_address     (req_bus_address),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_target          (rsp_target),
      .rsp_physical_offset (rsp_physical_offset),
      .rsp_rtc_index       (rsp_rtc_index),
      .rsp_store_data      (rsp_store_data),
      .rsp_current_rom_bank(rsp_current_rom_bank),
      .rsp_current_ram_bank(rsp_current_ram_bank)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The header type byte decides which register map the cartridge has.
   function automatic kind_type decode_mapper(input logic [7:0] cart);
      if (cart >= 8'h01 && cart <= 8'h03) return KIND_MBC1;
      if (cart == 8'h05 || cart == 8'h06) return KIND_MBC2;
      if (cart >= 8'h0F && cart <= 8'h13) return KIND_MBC3;
      if (cart >= 8'h19 && cart <= 8'h1E) return KIND_MBC5;
      return KIND_NONE;
   endfunction

   // Predicts one access. A control write updates the mapper registers first, so the
   // bank fields of the response show the registers as they stand after the access.
   function automatic translation_type translate_access(input item_type acc);
      translation_type res;
      kind_type        kind;
      logic [15:0]     a;
      logic [7:0]      v;
      logic [31:0]     rom_mask, offset;
      int              size_log2;
      a    = acc.addr;
      v    = acc.data;
      kind = decode_mapper(cart_type_cfg);
      size_log2 = int'(rom_log2_cfg);
      if (size_log2 < int'(ROM_LOG2_MIN)) size_log2 = int'(ROM_LOG2_MIN);
      if (size_log2 > ROM_LOG2_MAX) size_log2 = ROM_LOG2_MAX;
      rom_mask = (32'd1 << size_log2) - 32'd1;
      offset   = '0;
      res      = '0;
      res.store_data = (acc.opcode == OP_WRITE) ? v : 8'h00;
      if (a < 16'h8000 && acc.opcode == OP_WRITE) begin
         res.target = TGT_CONTROL;
         case (kind)
            KIND_MBC1: begin
               if (a < 16'h2000) begin
                  mapper_regs.ram_enable = (v[3:0] == 4'hA);
               end else if (a < 16'h4000) begin
                  // A zero in the five low bank bits selects bank one instead.
                  mapper_regs.rom_bank = (mapper_regs.rom_bank & 9'h060) |
                     ((v[4:0] == 5'd0) ? 9'd1 : {4'd0, v[4:0]});
               end else if (a < 16'h6000) begin
                  if (!mapper_regs.banking_mode)
                     mapper_regs.rom_bank = {2'b00, v[1:0], mapper_regs.rom_bank[4:0]};
                  else
                     mapper_regs.ram_bank = {2'b00, v[1:0]};
               end else begin
                  mapper_regs.banking_mode = v[0];
               end
            end
            KIND_MBC2: begin
               if (a < 16'h4000) begin
                  if (!a[8])
                     mapper_regs.ram_enable = (v[3:0] == 4'hA);
                  else
                     mapper_regs.rom_bank = (v[3:0] == 4'd0) ? 9'd1 : {5'd0, v[3:0]};
               end
            end
            KIND_MBC3: begin
               if (a < 16'h2000) begin
                  mapper_regs.ram_enable = (v[3:0] == 4'hA);
               end else if (a < 16'h4000) begin
                  mapper_regs.rom_bank = (v[6:0] == 7'd0) ? 9'd1 : {2'd0, v[6:0]};
               end else if (a < 16'h6000) begin
                  // Banks 0-3 select RAM, 08-0C select an RTC register, all else is dropped.
                  if (v <= 8'h03) begin
                     mapper_regs.ram_bank   = v[3:0];
                     mapper_regs.rtc_select = 1'b0;
                  end else if (v >= 8'h08 && v <= 8'h0C) begin
                     mapper_regs.ram_bank   = v[3:0];
                     mapper_regs.rtc_select = 1'b1;
                  end
               end
            end
            KIND_MBC5: begin
               if (a < 16'h2000)
                  mapper_regs.ram_enable = (v[3:0] == 4'hA);
               else if (a < 16'h3000)
                  mapper_regs.rom_bank = {mapper_regs.rom_bank[8], v};
               else if (a < 16'h4000)
                  mapper_regs.rom_bank = {v[0], mapper_regs.rom_bank[7:0]};
               else if (a < 16'h6000)
                  mapper_regs.ram_bank = v[3:0];
            end
            default: begin
            end
         endcase
      end else if (a < 16'h8000) begin
         res.target = TGT_ROM;
         if (a < 16'h4000) begin
            offset = {16'd0, a};
            if (kind == KIND_MBC1 && mapper_regs.banking_mode)
               offset = offset | (32'(mapper_regs.rom_bank & 9'h060) << 14);
         end else begin
            offset = (32'(mapper_regs.rom_bank) << 14) | 32'(a[13:0]);
         end
         // Bank zero is wrapped by the ROM size as well as the switched window.
         offset = offset & rom_mask;
      end else if (a >= 16'hA000 && a < 16'hC000) begin
         if (!mapper_regs.ram_enable) begin
            res.target = TGT_DISABLED;
         end else if (kind == KIND_MBC2) begin
            res.target     = TGT_NIBBLE;
            offset         = 32'(a & 16'h01FF);
            res.store_data = res.store_data & 8'h0F;
         end else if (kind == KIND_MBC3 && mapper_regs.rtc_select) begin
            // A stale select left by another mapper kind points at no RTC register.
            if (mapper_regs.ram_bank >= 4'h8 && mapper_regs.ram_bank <= 4'hC) begin
               res.target    = TGT_RTC;
               res.rtc_index = 3'(mapper_regs.ram_bank - 4'h8);
            end else begin
               res.target = TGT_DISABLED;
            end
         end else begin
            res.target = TGT_EXT_RAM;
            offset = ((32'(mapper_regs.ram_bank) << 13) | 32'(a[12:0])) &
                     ((32'd1 << EXT_RAM_BITS) - 32'd1);
         end
      end else begin
         res.target = TGT_NOT_CART;
      end
      res.offset   = offset[22:0];
      res.rom_bank = mapper_regs.rom_bank;
      res.ram_bank = mapper_regs.ram_bank;
      return res;
   endfunction

   // Most gaps are short, a few are long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic check_field(input string field_name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0h, got %0h", field_name, expected, actual);
         mismatch_count++;
      end
   endtask

   task automatic add_access(input logic op, input logic [15:0] addr,
                             input logic [7:0] data);
      item_type acc;
      acc.opcode = op;
      acc.addr   = addr;
      acc.data   = data;
      access_queue = {access_queue, acc};
   endtask

   // Both configuration registers are written one after the other while the block is idle.
   task automatic program_mapper(input logic [7:0] cart, input logic [4:0] size_log2);
      for (int i = 0; i < 2; i++) begin
         @(negedge clock);
         csr_valid      <= 1'b1;
         csr_index      <= (i == 0) ? CSR_CART_TYPE : CSR_ROM_LOG2;
         csr_write_data <= (i == 0) ? cart : {3'b000, size_log2};
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
         csr_valid <= 1'b0;
      end
      settings_used++;
   endtask

   // Waits until every queued access has been driven and answered, then lets the
   // pipeline settle before anything touches the configuration.
   task automatic wait_idle();
      while (access_queue.size() != 0 || req_valid || expected_translations.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver. A beat that is offered stays on the bus unchanged until the
   // block takes it; only then does the driver move on to a gap or the next access.
   // The valid level is worked out first and assigned once per falling edge.
   always @(negedge clock) begin
      logic     drive_valid;
      item_type next_access;
      drive_valid = req_valid;
      if (!reset && (!req_valid || req_beat)) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            drive_valid = 1'b0;
         end else if (access_queue.size() > 0) begin
            next_access      = access_queue.pop_front();
            req_opcode      <= next_access.opcode;
            req_bus_address <= next_access.addr;
            req_write_data  <= next_access.data;
            drive_valid      = 1'b1;
            // Now and then a stretch of back-to-back beats with no gaps at all.
            if (req_calm_left > 0) begin
               req_calm_left--;
               req_gap_left = 0;
            end else begin
               req_gap_left = pick_gap();
               if ($urandom_range(0, 99) < 3) req_calm_left = $urandom_range(30, 120);
            end
         end else begin
            drive_valid = 1'b0;
         end
      end
      req_valid <= drive_valid;
   end

   // Response receiver. Besides short random stalls it holds off once for a long
   // stretch while plenty of accesses are still queued, so the block backs up and
   // has to stall its request side.
   always @(negedge clock) begin
      logic accept_next;
      accept_next = 1'b0;
      if (!reset) begin
         if (long_hold_left > 0) begin
            long_hold_left--;
         end else if (!long_hold_done && results_checked >= 300 &&
                      access_queue.size() > 40) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES;
         end else if (rsp_hold_left > 0) begin
            rsp_hold_left--;
         end else begin
            accept_next = 1'b1;
            if (rsp_calm_left > 0) begin
               rsp_calm_left--;
            end else begin
               rsp_hold_left = pick_gap();
               if ($urandom_range(0, 99) < 3) rsp_calm_left = $urandom_range(50, 150);
            end
         end
      end
      rsp_ready <= accept_next;
   end

   // Monitor. Everything is sampled at the rising edge: configuration beats update
   // the predicted registers, request beats queue their translation, and response
   // beats are checked against the oldest translation still outstanding.
   always @(posedge clock) begin
      translation_type oldest;
      translation_type predicted;
      req_beat <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CART_TYPE: cart_type_cfg = csr_write_data;
               CSR_ROM_LOG2:  rom_log2_cfg  = csr_write_data[4:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            predicted = translate_access('{req_opcode, req_bus_address, req_write_data});
            expected_translations = {expected_translations, predicted};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_translations.size() == 0) begin
               $error("response beat arrived with no access outstanding");
               mismatch_count++;
            end else begin
               oldest = expected_translations.pop_front();
               check_field("target", 32'(oldest.target), 32'(rsp_target));
               check_field("physical_offset", 32'(oldest.offset), 32'(rsp_physical_offset));
               check_field("rtc_index", 32'(oldest.rtc_index), 32'(rsp_rtc_index));
               check_field("store_data", 32'(oldest.store_data), 32'(rsp_store_data));
               check_field("current_rom_bank", 32'(oldest.rom_bank),
                           32'(rsp_current_rom_bank));
               check_field("current_ram_bank", 32'(oldest.ram_bank),
                           32'(rsp_current_ram_bank));
               target_hits[int'(oldest.target)]++;
               results_checked++;
            end
         end
      end
   end

   // Watchdog: a run in which no beat of any kind moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_valid && req_ready) ||
          (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("no beat moved for %0d cycles", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      item_type   acc;
      logic [7:0] cart;
      logic [4:0] size_log2;
      int         sel, flavor;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out of reset no mapper is selected: ROM reads pass straight through, mapper
      // writes change nothing, and RAM is disabled.
      add_access(OP_READ,  16'h7FFF, 8'h00);
      add_access(OP_WRITE, 16'h2000, 8'hFF);
      add_access(OP_READ,  16'hA000, 8'hFF);
      add_access(OP_WRITE, 16'h8000, 8'hFF);
      add_access(OP_READ,  16'hFFFF, 8'h00);
      wait_idle();

      // MBC1 with the largest ROM: bank zero selects bank one, the upper bank bits,
      // mode one moving the fixed window, and a RAM bank in mode one.
      program_mapper(8'h01, 5'd23);
      add_access(OP_WRITE, 16'h0000, 8'h0A);
      add_access(OP_WRITE, 16'h2000, 8'h00);
      add_access(OP_WRITE, 16'h4000, 8'h03);
      add_access(OP_WRITE, 16'h6000, 8'h01);
      add_access(OP_READ,  16'h0123, 8'h00);
      add_access(OP_WRITE, 16'h4000, 8'h02);
      add_access(OP_READ,  16'hBFFF, 8'h00);
      add_access(OP_READ,  16'h7FFF, 8'h00);
      wait_idle();

      // MBC2 with the smallest ROM: a zero bank nibble, nibble RAM masking the stored
      // byte, and a switched bank wrapped by the 32 KiB ROM.
      program_mapper(8'h05, 5'd15);
      add_access(OP_WRITE, 16'h0100, 8'h10);
      add_access(OP_WRITE, 16'h0000, 8'h0A);
      add_access(OP_WRITE, 16'hA1FF, 8'hFF);
      add_access(OP_WRITE, 16'h0100, 8'hF7);
      add_access(OP_READ,  16'h7FFF, 8'h00);
      wait_idle();

      // MBC3: the highest RTC register, and a bank write whose low seven bits are zero.
      program_mapper(8'h13, 5'd15);
      add_access(OP_WRITE, 16'h4000, 8'h0C);
      add_access(OP_READ,  16'hA000, 8'h00);
      add_access(OP_WRITE, 16'h2000, 8'h80);
      wait_idle();

      // A RAM bank set under MBC1 leaves the RTC select stale; back on MBC3 the RAM
      // window must then answer as disabled until a plain RAM bank is chosen again.
      program_mapper(8'h03, 5'd15);
      add_access(OP_WRITE, 16'h4000, 8'h01);
      wait_idle();
      program_mapper(8'h0F, 5'd15);
      add_access(OP_READ,  16'hA000, 8'h00);
      add_access(OP_WRITE, 16'h4000, 8'h00);
      wait_idle();

      // MBC5: the full nine-bit ROM bank and the highest RAM bank.
      program_mapper(8'h1E, 5'd23);
      add_access(OP_WRITE, 16'h2000, 8'hFF);
      add_access(OP_WRITE, 16'h3000, 8'h01);
      add_access(OP_READ,  16'h7FFF, 8'h00);
      add_access(OP_WRITE, 16'h4000, 8'hFF);
      add_access(OP_READ,  16'hBFFF, 8'h00);
      wait_idle();

      // Random phases. Most accesses are mapper writes with values that matter (RAM
      // enable, small banks, RTC selects), ROM reads and RAM-window accesses, so the
      // mapper walks through its states; the rest are arbitrary beats. Register
      // state carries over from one cartridge type to the next on purpose.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         cart = (p == RANDOM_PHASES - 1) ? 8'($urandom_range(0, 255)) : PHASE_TYPES[p];
         if (p == 0)
            size_log2 = 5'd23;
         else if (p == 1)
            size_log2 = 5'd15;
         else
            size_log2 = 5'($urandom_range(15, 23));
         program_mapper(cart, size_log2);
         repeat (ITEMS_PER_PHASE) begin
            sel = $urandom_range(0, 99);
            acc.opcode = 1'($urandom);
            acc.addr   = 16'($urandom);
            acc.data   = 8'($urandom);
            if (sel < 35) begin
               acc.opcode = OP_WRITE;
               acc.addr   = 16'($urandom_range(0, 16'h7FFF));
               flavor     = $urandom_range(0, 4);
               case (flavor)
                  0: acc.data = {4'($urandom), 4'hA};
                  1: acc.data = 8'($urandom_range(0, 3));
                  2: acc.data = 8'($urandom_range(8, 12));
                  default: begin
                  end
               endcase
            end else if (sel < 60) begin
               acc.opcode = OP_READ;
               acc.addr   = 16'($urandom_range(0, 16'h7FFF));
            end else if (sel < 85) begin
               acc.addr = 16'($urandom_range(16'hA000, 16'hBFFF));
            end
            access_queue = {access_queue, acc};
         end
         wait_idle();
      end

      if (expected_translations.size() != 0) begin
         $error("%0d translations never received a response", expected_translations.size());
         mismatch_count++;
      end
      $display("Run covered %0d checked accesses under %0d mapper settings.",
               results_checked, settings_used);
      $display("Targets: rom %0d, ext ram %0d, nibble %0d, rtc %0d, disabled %0d, %s %0d, %s %0d",
               target_hits[0], target_hits[1], target_hits[2], target_hits[3],
               target_hits[4], "not cart", target_hits[5], "control", target_hits[6]);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_core.sv
rtl/cartridge_bank_mapper.sv
test/cartridge_bank_mapper_tb.sv
